[design/ckl_pkg.sv]
// Shared constants, codes and types of the compacting keyed list.
`timescale 1ns / 1ps
`default_nettype none

package ckl_pkg;

    // Sizing
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed port widths
    localparam int NAME_W = 64;
    localparam int AMT_W  = 32;
    localparam int OCNT_W = 5;

    // Request actions (code 3 is unused and ignored)
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LIST   = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_status;

    // What every cell does in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    // Command broadcast from the controller to the row of cells
    typedef struct packed {
        t_cell_op         op;
        logic [CNT_W-1:0] pos;    // load slot, or wrap slot when rotating
        logic [CNT_W-1:0] count;  // entries held
        logic             cmp;    // capture name compare
    } t_cell_cmd;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } t_state;

endpackage

`default_nettype wire

[design/compacting_keyed_list.sv]
// Compacting keyed list: fixed-capacity ordered list built as a row of cells.
//
// Input channel (i_valid / o_stall) carries one request: insert at tail,
// remove first entry with a matching name, or list all entries. Action
// code 3 is dropped without a result. Output channel (o_valid / i_stall)
// gives one result for insert, remove and an empty list; a list of N
// entries gives N results in order, the final one marked by o_last.
// Timing: a request is taken in the idle state, and its result is registered
// in the work state once the output register is free; no new request is
// taken until the work ends. For a non-empty list the cells rotate one place
// per result toward cell 0, which feeds the output register, and are back
// in place after N steps. Remove finds the first match through a compare
// captured in every cell and an OR chain running up the row.
// While a request is in work o_stall is high. When the receiver stalls, the
// output register holds its result and the block waits before loading the
// next one; no result is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the list and clears the output
// valid; entry contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module compacting_keyed_list (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [1:0]                          i_action,
    input  wire  [ckl_pkg::NAME_W-1:0]          i_name_key,
    input  wire  [ckl_pkg::NAME_W-1:0]          i_type_key,
    input  wire signed [ckl_pkg::AMT_W-1:0]     i_amount,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [1:0]                          o_status,
    output logic [ckl_pkg::OCNT_W-1:0]          o_entry_count,
    output logic [ckl_pkg::NAME_W-1:0]          o_out_name,
    output logic [ckl_pkg::NAME_W-1:0]          o_out_type,
    output logic signed [ckl_pkg::AMT_W-1:0]    o_out_amount,
    output logic                                o_last
);

    localparam int CAP   = ckl_pkg::CAPACITY;
    localparam int KB    = ckl_pkg::KEY_BITS;
    localparam int CW    = ckl_pkg::CNT_W;

    // Control state
    ckl_pkg::t_state         r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;

    // Request held during work
    ckl_pkg::t_action        r_action;
    logic [KB-1:0]           r_name;
    logic [KB-1:0]           r_type;
    logic signed [ckl_pkg::AMT_W-1:0] r_amount;

    // Output register
    logic                    r_o_valid;
    ckl_pkg::t_status        r_status, n_status;
    logic [ckl_pkg::OCNT_W-1:0] r_o_count, n_o_count;
    logic [ckl_pkg::NAME_W-1:0] r_o_name, n_o_name;
    logic [ckl_pkg::NAME_W-1:0] r_o_type, n_o_type;
    logic signed [ckl_pkg::AMT_W-1:0] r_o_amount, n_o_amount;
    logic                    r_last, n_last;
    logic                    w_load_out;
    logic                    w_out_free;
    logic                    w_accept;

    // Cell row
    ckl_pkg::t_cell_cmd      w_cmd;
    logic [KB-1:0]           w_key;
    logic [KB-1:0]           w_cname [CAP];
    logic [KB-1:0]           w_ctype [CAP];
    logic signed [ckl_pkg::AMT_W-1:0] w_camt [CAP];
    logic                    w_prefix [CAP+1];
    logic                    w_found;

    assign w_key       = i_name_key[KB-1:0];
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_prefix[0] = 1'b0;
    assign w_found     = w_prefix[CAP];

    // Row of cells, each fed by its upper neighbor
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        ckl_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_index       (CW'(g)),
            .i_key         (w_key),
            .i_new_name    (r_name),
            .i_new_type    (r_type),
            .i_new_amount  (r_amount),
            .i_nbr_name    (w_cname[(g + 1) % CAP]),
            .i_nbr_type    (w_ctype[(g + 1) % CAP]),
            .i_nbr_amount  (w_camt[(g + 1) % CAP]),
            .i_head_name   (w_cname[0]),
            .i_head_type   (w_ctype[0]),
            .i_head_amount (w_camt[0]),
            .i_prefix      (w_prefix[g]),
            .o_prefix      (w_prefix[g+1]),
            .o_name        (w_cname[g]),
            .o_type        (w_ctype[g]),
            .o_amount      (w_camt[g])
        );
    end

    // Controller state and list count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckl_pkg::ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= ckl_pkg::t_action'(i_action);
            r_name   <= i_name_key[KB-1:0];
            r_type   <= i_type_key[KB-1:0];
            r_amount <= i_amount;
        end
    end

    // Next state, cell command and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        w_load_out = 1'b0;
        n_status   = ckl_pkg::STAT_OK;
        n_o_count  = ckl_pkg::OCNT_W'(r_count);
        n_o_name   = '0;
        n_o_type   = '0;
        n_o_amount = '0;
        n_last     = 1'b1;
        w_cmd.op    = ckl_pkg::CELL_HOLD;
        w_cmd.pos   = r_count;
        w_cmd.count = r_count;
        w_cmd.cmp   = 1'b0;
        case (r_state)
            ckl_pkg::ST_IDLE: begin
                w_cmd.cmp = w_accept;
                if (w_accept) begin
                    n_state = ckl_pkg::ST_EXEC;
                end
            end
            ckl_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    n_state = ckl_pkg::ST_IDLE;
                    case (r_action)
                        ckl_pkg::ACT_INSERT: begin
                            w_load_out = 1'b1;
                            if (r_count == CW'(CAP)) begin
                                n_status = ckl_pkg::STAT_FULL;
                            end else begin
                                w_cmd.op  = ckl_pkg::CELL_LOAD;
                                n_count   = r_count + CW'(1);
                                n_o_count = ckl_pkg::OCNT_W'(n_count);
                            end
                        end
                        ckl_pkg::ACT_REMOVE: begin
                            w_load_out = 1'b1;
                            if (!w_found) begin
                                n_status = ckl_pkg::STAT_MISSING;
                            end else begin
                                w_cmd.op  = ckl_pkg::CELL_SHIFT;
                                n_count   = r_count - CW'(1);
                                n_o_count = ckl_pkg::OCNT_W'(n_count);
                            end
                        end
                        ckl_pkg::ACT_LIST: begin
                            if (r_count == '0) begin
                                w_load_out = 1'b1;
                                n_status   = ckl_pkg::STAT_EMPTY;
                            end else begin
                                n_state = ckl_pkg::ST_LIST;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ckl_pkg::ST_LIST: begin
                // emit the head cell, then rotate the held entries by one
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_o_name   = ckl_pkg::NAME_W'(w_cname[0]);
                    n_o_type   = ckl_pkg::NAME_W'(w_ctype[0]);
                    n_o_amount = w_camt[0];
                    n_last     = (r_idx == r_count - CW'(1));
                    w_cmd.op   = ckl_pkg::CELL_ROTATE;
                    w_cmd.pos  = r_count - CW'(1);
                    n_idx      = r_idx + CW'(1);
                    if (n_last) begin
                        n_state = ckl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ckl_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_status   <= n_status;
            r_o_count  <= n_o_count;
            r_o_name   <= n_o_name;
            r_o_type   <= n_o_type;
            r_o_amount <= n_o_amount;
            r_last     <= n_last;
        end
    end

    assign o_stall       = (r_state != ckl_pkg::ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_o_count;
    assign o_out_name    = r_o_name;
    assign o_out_type    = r_o_type;
    assign o_out_amount  = r_o_amount;
    assign o_last        = r_last;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("entry count above capacity");

    a_list_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ckl_pkg::ST_LIST) |-> (r_idx < r_count))
        else $error("list index past held entries");

    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ckl_pkg::ST_EXEC))
        else $error("taken request did not start work");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
            || r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && n_status == ckl_pkg::STAT_FULL) |-> (r_count == CW'(CAP)))
        else $error("full reported below capacity");

endmodule

`default_nettype wire

[design/ckl_cell.sv]
// One list cell: holds one entry, compares its name, takes its neighbor's entry.
`timescale 1ns / 1ps
`default_nettype none

module ckl_cell (
    input  wire                                 i_clk,
    input  wire ckl_pkg::t_cell_cmd             i_cmd,
    input  wire  [ckl_pkg::CNT_W-1:0]           i_index,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_key,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_new_name,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_new_type,
    input  wire signed [ckl_pkg::AMT_W-1:0]     i_new_amount,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_nbr_name,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_nbr_type,
    input  wire signed [ckl_pkg::AMT_W-1:0]     i_nbr_amount,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_head_name,
    input  wire  [ckl_pkg::KEY_BITS-1:0]        i_head_type,
    input  wire signed [ckl_pkg::AMT_W-1:0]     i_head_amount,
    input  wire                                 i_prefix,
    output logic                                o_prefix,
    output logic [ckl_pkg::KEY_BITS-1:0]        o_name,
    output logic [ckl_pkg::KEY_BITS-1:0]        o_type,
    output logic signed [ckl_pkg::AMT_W-1:0]    o_amount
);

    logic [ckl_pkg::KEY_BITS-1:0]     r_name;
    logic [ckl_pkg::KEY_BITS-1:0]     r_type;
    logic signed [ckl_pkg::AMT_W-1:0] r_amount;
    logic                             r_hit;
    logic                             w_live;

    // Only held entries take part in the first-match chain
    assign w_live   = (i_index < i_cmd.count);
    assign o_prefix = i_prefix | (r_hit & w_live);

    assign o_name   = r_name;
    assign o_type   = r_type;
    assign o_amount = r_amount;

    // Name compare, captured when the request is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_hit <= (r_name == i_key);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ckl_pkg::CELL_LOAD: begin
                if (i_index == i_cmd.pos) begin
                    r_name   <= i_new_name;
                    r_type   <= i_new_type;
                    r_amount <= i_new_amount;
                end
            end
            ckl_pkg::CELL_SHIFT: begin
                // first match and everything above it move down one place
                if (o_prefix) begin
                    r_name   <= i_nbr_name;
                    r_type   <= i_nbr_type;
                    r_amount <= i_nbr_amount;
                end
            end
            ckl_pkg::CELL_ROTATE: begin
                // head wraps into the last held slot
                if (i_index == i_cmd.pos) begin
                    r_name   <= i_head_name;
                    r_type   <= i_head_type;
                    r_amount <= i_head_amount;
                end else if (i_index < i_cmd.pos) begin
                    r_name   <= i_nbr_name;
                    r_type   <= i_nbr_type;
                    r_amount <= i_nbr_amount;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
